@@ sv/id3v2_frame_walker_unit_macros.svh @@
`ifndef ID3V2_FRAME_WALKER_UNIT_MACROS_SVH
`define ID3V2_FRAME_WALKER_UNIT_MACROS_SVH

// expression must hold at every edge out of reset
`define ID3FW_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("id3fw check failed");

// consequent must hold in the same cycle as the antecedent
`define ID3FW_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("id3fw check failed");

`endif

@@ sv/id3fw_pkg.sv @@
package id3fw_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CountOutW  = 16;
   localparam int SizeW      = 28;
   localparam int IdW        = 32;

   localparam logic [3:0] HDR_ID_LAST   = 4'd3;
   localparam logic [3:0] HDR_SIZE_LAST = 4'd7;
   localparam logic [3:0] HDR_FLAG0     = 4'd8;
   localparam logic [3:0] HDR_FLAG1     = 4'd9;

   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHR_DIGIT_9 = 8'h39;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_END   = 1'b1;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_SKIP,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [3:0]             hdr_idx;
      logic [IdW-1:0]         id_shift;
      logic [SizeW-1:0]       size_accum;
      logic [7:0]             flag0;
      logic [SizeW-1:0]       skip_left;
      logic [COUNT_BITS-1:0]  frames_seen;
   } walk_state_type;

   typedef struct packed {
      logic                   kind;
      logic [IdW-1:0]         frame_tag;
      logic [SizeW-1:0]       payload_len;
      logic [7:0]             frame_flags;
      logic [CountOutW-1:0]   frame_count;
   } result_type;

   localparam walk_state_type WALK_RESET = '{
      phase:       PH_HEADER,
      hdr_idx:     '0,
      id_shift:    '0,
      size_accum:  '0,
      flag0:       '0,
      skip_left:   '0,
      frames_seen: '0
   };

   function automatic logic is_id_char(input logic [7:0] b);
      return (b inside {[CHR_UPPER_A:CHR_UPPER_Z], [CHR_DIGIT_0:CHR_DIGIT_9]});
   endfunction

   // v2.4 flag layout, masks taken per bit
   function automatic logic [7:0] decode_flags(input logic [7:0] f0, input logic [7:0] f1);
      return {f0[6], f0[5], f0[4], f1[6], f1[3], f1[2], f1[1], f1[0]};
   endfunction

   // low bits of the frame counter, zero filled when the counter is narrow
   function automatic logic [CountOutW-1:0] count_out(input logic [COUNT_BITS-1:0] c);
      logic [CountOutW-1:0] r;
      r = '0;
      for (int i = 0; i < CountOutW; i++) begin
         if (i < COUNT_BITS) begin
            r[i] = c[i];
         end
      end
      return r;
   endfunction

endpackage

@@ sv/id3fw_if.sv @@
interface id3fw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_req;

   modport source (output valid, output data_byte, output start_req, input ready);
   modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface id3fw_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             kind;
   logic [id3fw_pkg::IdW-1:0]        frame_tag;
   logic [id3fw_pkg::SizeW-1:0]      payload_len;
   logic [7:0]                       frame_flags;
   logic [id3fw_pkg::CountOutW-1:0]  frame_count;

   modport source (output valid, output kind, output frame_tag, output payload_len,
                   output frame_flags, output frame_count, input ready);
   modport sink   (input valid, input kind, input frame_tag, input payload_len,
                   input frame_flags, input frame_count, output ready);
endinterface

@@ sv/id3fw_step.sv @@
module id3fw_step (
   input  id3fw_pkg::walk_state_type cur_state,
   input  logic [7:0]                data_byte,
   input  logic                      start_req,
   output id3fw_pkg::walk_state_type next_state,
   output logic                      res_valid,
   output id3fw_pkg::result_type     res
);

   id3fw_pkg::walk_state_type s;
   logic [id3fw_pkg::SizeW-1:0] skip_dec;

   always_comb begin
      s          = start_req ? id3fw_pkg::WALK_RESET : cur_state;
      next_state = s;
      res_valid  = 1'b0;
      res        = '0;
      skip_dec   = s.skip_left - id3fw_pkg::SizeW'(1);

      case (s.phase)
         id3fw_pkg::PH_DONE: begin
            next_state = s;
         end
         id3fw_pkg::PH_SKIP: begin
            next_state.skip_left = skip_dec;
            if (skip_dec == '0) begin
               next_state.phase = id3fw_pkg::PH_HEADER;
            end
         end
         id3fw_pkg::PH_HEADER: begin
            if (s.hdr_idx <= id3fw_pkg::HDR_ID_LAST) begin
               if (!id3fw_pkg::is_id_char(data_byte)) begin
                  res_valid           = 1'b1;
                  res.kind            = id3fw_pkg::KIND_END;
                  res.frame_count     = id3fw_pkg::count_out(s.frames_seen);
                  next_state.phase    = id3fw_pkg::PH_DONE;
                  next_state.hdr_idx  = '0;
               end else begin
                  next_state.id_shift = {s.id_shift[id3fw_pkg::IdW-9:0], data_byte};
                  next_state.hdr_idx  = s.hdr_idx + 4'd1;
               end
            end else if (s.hdr_idx <= id3fw_pkg::HDR_SIZE_LAST) begin
               // syncsafe: seven bits a byte, top bit dropped
               next_state.size_accum = {s.size_accum[id3fw_pkg::SizeW-8:0], data_byte[6:0]};
               next_state.hdr_idx    = s.hdr_idx + 4'd1;
            end else if (s.hdr_idx == id3fw_pkg::HDR_FLAG0) begin
               next_state.flag0   = data_byte;
               next_state.hdr_idx = id3fw_pkg::HDR_FLAG1;
            end else begin
               res_valid       = 1'b1;
               res.kind        = id3fw_pkg::KIND_FRAME;
               res.frame_tag   = s.id_shift;
               res.payload_len = s.size_accum;
               res.frame_flags = id3fw_pkg::decode_flags(s.flag0, data_byte);
               res.frame_count = id3fw_pkg::count_out(s.frames_seen);
               if (s.frames_seen != '1) begin
                  next_state.frames_seen = s.frames_seen + id3fw_pkg::COUNT_BITS'(1);
               end
               next_state.skip_left  = s.size_accum;
               next_state.phase      = (s.size_accum != '0) ? id3fw_pkg::PH_SKIP
                                                            : id3fw_pkg::PH_HEADER;
               next_state.hdr_idx    = '0;
               next_state.id_shift   = '0;
               next_state.size_accum = '0;
               next_state.flag0      = '0;
            end
         end
         default: begin
            next_state = s;
         end
      endcase
   end

endmodule

@@ sv/id3v2_frame_walker_unit.sv @@
// A taken byte passes the input register and the step logic, and its result item is held in the result register.
// Throughput: one byte per cycle while rsp is not stalled; the walk state updates in a single pass of the step logic.
// A stalled rsp holds the pipeline; req stays ready while the input stage can move on.
// Reset (synchronous, active high) empties both stages and puts the walker in header phase
// with a zero frame count, so a walk may begin without start_req.
`include "id3v2_frame_walker_unit_macros.svh"

module id3v2_frame_walker_unit (
   input  logic                clock,
   input  logic                reset,
   id3fw_req_if.sink           req_ch,
   id3fw_rsp_if.source         rsp_ch
);

   // input stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   // walk state
   id3fw_pkg::walk_state_type state_ff, state_in;

   // result stage
   logic                  rsp_valid_ff, rsp_valid_in;
   id3fw_pkg::result_type rsp_ff;

   logic                  step_valid;
   id3fw_pkg::result_type step_res;
   logic                  advance;
   logic                  req_take;

   // the input stage moves when the result register is free or being drained
   assign advance       = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = !in_valid_ff || advance;
   assign req_take      = req_ch.valid && req_ch.ready;

   id3fw_step u_step (
      .cur_state  (state_ff),
      .data_byte  (in_byte_ff),
      .start_req  (in_start_ff),
      .next_state (state_in),
      .res_valid  (step_valid),
      .res        (step_res)
   );

   always_comb begin
      in_valid_in  = req_ch.ready ? req_take : in_valid_ff;
      rsp_valid_in = advance ? (in_valid_ff && step_valid) : rsp_valid_ff;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= id3fw_pkg::WALK_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_valid_ff && advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_ch.data_byte;
         in_start_ff <= req_ch.start_req;
      end
      if (advance && in_valid_ff && step_valid) begin
         rsp_ff <= step_res;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = rsp_ff.kind;
   assign rsp_ch.frame_tag   = rsp_ff.frame_tag;
   assign rsp_ch.payload_len = rsp_ff.payload_len;
   assign rsp_ch.frame_flags = rsp_ff.frame_flags;
   assign rsp_ch.frame_count = rsp_ff.frame_count;

   // header position never runs past the second flag byte
   `ID3FW_ASSERT_ALWAYS(a_hdr_idx_range, clock, reset, state_ff.hdr_idx <= id3fw_pkg::HDR_FLAG1)
   // payload skip is only entered with bytes left to pass
   `ID3FW_ASSERT_IMPLIES(a_skip_nonzero, clock, reset, state_ff.phase == id3fw_pkg::PH_SKIP, state_ff.skip_left != '0)
   // once the walk has ended, nothing is reported until a new start
   `ID3FW_ASSERT_IMPLIES(a_done_silent, clock, reset, in_valid_ff && !in_start_ff && state_ff.phase == id3fw_pkg::PH_DONE, !step_valid)

endmodule

@@ sim/id3v2_frame_walker_unit_test.sv @@
`timescale 1ns / 1ps

module id3v2_frame_walker_unit_test;

   // random-phase length in counted bytes; bytes the walker only ignores are left out
   localparam int RANDOM_BYTES  = 1750;
   // cycles with no handshake while work is outstanding before the run is called dead
   localparam int STALL_LIMIT   = 2000;
   // receiver hold pattern, walked one bit per cycle
   localparam logic [12:0] HOLD_PATTERN = 13'b0110_0100_0111_0;

   typedef struct {
      logic [7:0] data;
      logic       st;
   } byte_item;

   logic clock;
   logic reset;

   id3fw_req_if req_bus ();
   id3fw_rsp_if rsp_bus ();

   id3v2_frame_walker_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Stimulus store and expected results
   // ---------------------------------------------------------------------------------
   byte_item              pending_bytes[$];
   id3fw_pkg::result_type frames_due[$];
   int                    walk_items = 0;
   int                    fault_count = 0;
   int                    idle_cycles;
   int                    gap_left;
   int                    burst_left;
   int                    stall_cyc;

   // ---------------------------------------------------------------------------------
   // Walker prediction: own copy of the walk state
   // ---------------------------------------------------------------------------------
   id3fw_pkg::phase_type             walk_phase;
   logic [3:0]                       hdr_pos;
   logic [id3fw_pkg::IdW-1:0]        id_acc;
   logic [id3fw_pkg::SizeW-1:0]      size_acc;
   logic [7:0]                       flag_hi;
   logic [id3fw_pkg::SizeW-1:0]      skip_left;
   logic [id3fw_pkg::COUNT_BITS-1:0] frame_total;

   function automatic bit legal_id_byte(input logic [7:0] b);
      return (b >= id3fw_pkg::CHR_UPPER_A && b <= id3fw_pkg::CHR_UPPER_Z) ||
             (b >= id3fw_pkg::CHR_DIGIT_0 && b <= id3fw_pkg::CHR_DIGIT_9);
   endfunction

   function automatic void walk_clear();
      walk_phase  = id3fw_pkg::PH_HEADER;
      hdr_pos     = '0;
      id_acc      = '0;
      size_acc    = '0;
      flag_hi     = '0;
      skip_left   = '0;
      frame_total = '0;
   endfunction

   // one accepted byte through the walk; queues the result item it causes, if any
   function automatic void walk_byte(input logic [7:0] b, input logic st);
      id3fw_pkg::result_type r;
      if (st) begin
         walk_clear();
      end
      if (walk_phase == id3fw_pkg::PH_DONE) begin
         return;
      end
      if (walk_phase == id3fw_pkg::PH_SKIP) begin
         skip_left = skip_left - 1'b1;
         if (skip_left == '0) begin
            walk_phase = id3fw_pkg::PH_HEADER;
         end
         return;
      end
      if (hdr_pos <= id3fw_pkg::HDR_ID_LAST) begin
         if (!legal_id_byte(b)) begin
            // walk over: report the total so far, everything else zero
            r.kind        = id3fw_pkg::KIND_END;
            r.frame_tag   = '0;
            r.payload_len = '0;
            r.frame_flags = '0;
            r.frame_count = id3fw_pkg::CountOutW'(frame_total);
            frames_due.push_back(r);
            walk_phase = id3fw_pkg::PH_DONE;
            hdr_pos    = '0;
            return;
         end
         id_acc  = {id_acc[id3fw_pkg::IdW-9:0], b};
         hdr_pos = hdr_pos + 1'b1;
      end else if (hdr_pos <= id3fw_pkg::HDR_SIZE_LAST) begin
         // syncsafe: top bit of each size byte dropped
         size_acc = {size_acc[id3fw_pkg::SizeW-8:0], b[6:0]};
         hdr_pos  = hdr_pos + 1'b1;
      end else if (hdr_pos == id3fw_pkg::HDR_FLAG0) begin
         flag_hi = b;
         hdr_pos = id3fw_pkg::HDR_FLAG1;
      end else begin
         r.kind        = id3fw_pkg::KIND_FRAME;
         r.frame_tag   = id_acc;
         r.payload_len = size_acc;
         r.frame_flags = {flag_hi[6:4], b[6], b[3:0]};
         r.frame_count = id3fw_pkg::CountOutW'(frame_total);
         frames_due.push_back(r);
         if (frame_total != '1) begin
            frame_total = frame_total + 1'b1;
         end
         skip_left  = size_acc;
         walk_phase = (size_acc != '0) ? id3fw_pkg::PH_SKIP : id3fw_pkg::PH_HEADER;
         hdr_pos    = '0;
         id_acc     = '0;
         size_acc   = '0;
         flag_hi    = '0;
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------
   function automatic void push_byte(input logic [7:0] b, input logic st, input bit counts);
      byte_item it;
      it.data  = b;
      it.st    = st;
      pending_bytes.push_back(it);
      if (counts) begin
         walk_items++;
      end
   endfunction

   function automatic logic [7:0] rand_id_byte();
      int r;
      r = $urandom_range(0, 35);
      return (r < 26) ? 8'(id3fw_pkg::CHR_UPPER_A + r)
                      : 8'(id3fw_pkg::CHR_DIGIT_0 + (r - 26));
   endfunction

   // half the time a byte hugging the legal ranges, else 8'h00, 8'hFF or any other illegal byte
   function automatic logic [7:0] rand_bad_byte();
      logic [7:0] b;
      case ($urandom_range(0, 7))
         0: b = 8'(id3fw_pkg::CHR_UPPER_A - 1);
         1: b = 8'(id3fw_pkg::CHR_UPPER_Z + 1);
         2: b = 8'(id3fw_pkg::CHR_DIGIT_0 - 1);
         3: b = 8'(id3fw_pkg::CHR_DIGIT_9 + 1);
         4: b = 8'h00;
         5: b = 8'hFF;
         default: begin
            b = 8'($urandom_range(0, 255));
            while (legal_id_byte(b)) begin
               b = 8'($urandom_range(0, 255));
            end
         end
      endcase
      return b;
   endfunction

   // ten header bytes: legal id, syncsafe size with random top bits, random flags
   function automatic void build_header(input logic [id3fw_pkg::SizeW-1:0] sz,
                                        output logic [7:0] hdr[10]);
      for (int i = 0; i < 4; i++) begin
         hdr[i] = rand_id_byte();
      end
      hdr[4] = {1'($urandom_range(0, 1)), sz[27:21]};
      hdr[5] = {1'($urandom_range(0, 1)), sz[20:14]};
      hdr[6] = {1'($urandom_range(0, 1)), sz[13:7]};
      hdr[7] = {1'($urandom_range(0, 1)), sz[6:0]};
      hdr[8] = 8'($urandom_range(0, 255));
      hdr[9] = 8'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------------------------
   // Sender: presents the head of pending_bytes in bursts with gaps between
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.data_byte <= '0;
         req_bus.start_req <= 1'b0;
         gap_left          <= 0;
         burst_left        <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            walk_byte(pending_bytes[0].data, pending_bytes[0].st);
            pending_bytes.pop_front();
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_bytes.size() != 0 && gap_left == 0) begin
               req_bus.valid     <= 1'b1;
               req_bus.data_byte <= pending_bytes[0].data;
               req_bus.start_req <= pending_bytes[0].st;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  case ($urandom_range(0, 15))
                     0:       gap_left <= $urandom_range(10, 15);
                     1, 2, 3,
                     4, 5:    gap_left <= 0;
                     default: gap_left <= $urandom_range(1, 6);
                  endcase
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_bus.valid <= 1'b0;
               if (gap_left != 0) begin
                  gap_left <= gap_left - 1;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver: checks each result item against the oldest expectation
   // ---------------------------------------------------------------------------------
   task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= 10) begin
            $display("%s mismatch: expected %0h, got %0h", what, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      id3fw_pkg::result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_cyc     <= 0;
      end else begin
         stall_cyc <= stall_cyc + 1;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (frames_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("unexpected item: kind %0d tag %0h length %0h flags %0h count %0h",
                           rsp_bus.kind, rsp_bus.frame_tag, rsp_bus.payload_len,
                           rsp_bus.frame_flags, rsp_bus.frame_count);
               end
            end else begin
               want = frames_due.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_bus.kind));
               check_field("frame_tag", want.frame_tag, rsp_bus.frame_tag);
               check_field("payload_len", 32'(want.payload_len), 32'(rsp_bus.payload_len));
               check_field("frame_flags", 32'(want.frame_flags), 32'(rsp_bus.frame_flags));
               check_field("frame_count", 32'(want.frame_count), 32'(rsp_bus.frame_count));
            end
         end
         // alternating stretches: stall on the pattern, then always ready
         rsp_bus.ready <= stall_cyc[9] || !HOLD_PATTERN[stall_cyc % 13];
      end
   end

   // ---------------------------------------------------------------------------------
   // Watchdog: counts cycles with no handshake while something is still owed
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (pending_bytes.size() == 0 && !req_bus.valid && frames_due.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------------------
   initial begin
      logic [7:0]                  hdr[10];
      logic [id3fw_pkg::SizeW-1:0] sz;
      bit                          lead;
      bit                          cut;
      int                          n;
      int                          nframes;
      int                          pick;

      clock = 1'b0;
      reset = 1'b1;
      walk_clear();

      // Directed. No start on the first byte: walk must run straight out of reset.
      // "Z9A0", size bytes with top bits set (size 2), all flag bits set, 2 payload bytes.
      push_byte(id3fw_pkg::CHR_UPPER_Z, 1'b0, 1'b1);
      push_byte(id3fw_pkg::CHR_DIGIT_9, 1'b0, 1'b1);
      push_byte(id3fw_pkg::CHR_UPPER_A, 1'b0, 1'b1);
      push_byte(id3fw_pkg::CHR_DIGIT_0, 1'b0, 1'b1);
      push_byte(8'h80, 1'b0, 1'b1);
      push_byte(8'h80, 1'b0, 1'b1);
      push_byte(8'h80, 1'b0, 1'b1);
      push_byte(8'h82, 1'b0, 1'b1);
      push_byte(8'hFF, 1'b0, 1'b1);
      push_byte(8'hFF, 1'b0, 1'b1);
      push_byte(8'h00, 1'b0, 1'b1);
      push_byte(8'hFF, 1'b0, 1'b1);
      // "0AZ9" with zero size: next byte is a header again
      push_byte(id3fw_pkg::CHR_DIGIT_0, 1'b0, 1'b1);
      push_byte(id3fw_pkg::CHR_UPPER_A, 1'b0, 1'b1);
      push_byte(id3fw_pkg::CHR_UPPER_Z, 1'b0, 1'b1);
      push_byte(id3fw_pkg::CHR_DIGIT_9, 1'b0, 1'b1);
      for (int i = 0; i < 6; i++) begin
         push_byte(8'h00, 1'b0, 1'b1);
      end
      // one below 'A' ends the walk; a legal byte after it is ignored
      push_byte(8'(id3fw_pkg::CHR_UPPER_A - 1), 1'b0, 1'b1);
      push_byte(id3fw_pkg::CHR_UPPER_A, 1'b0, 1'b0);
      // fresh start on a bad byte: end with zero frames
      push_byte(8'(id3fw_pkg::CHR_UPPER_Z + 1), 1'b1, 1'b1);
      // fresh start, bad byte in the second id position
      push_byte(id3fw_pkg::CHR_UPPER_A, 1'b1, 1'b1);
      push_byte(8'(id3fw_pkg::CHR_DIGIT_9 + 1), 1'b0, 1'b1);

      // Random frame areas. Each opens with start_req on its first byte.
      while (walk_items < RANDOM_BYTES) begin
         lead = 1'b1;
         if ($urandom_range(0, 19) == 0) begin
            // noise area
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) begin
               push_byte(8'($urandom_range(0, 255)), lead, 1'b1);
               lead = 1'b0;
            end
            continue;
         end
         nframes = $urandom_range(0, 5);
         cut     = 1'b0;
         for (int f = 0; f < nframes && !cut; f++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               sz = id3fw_pkg::SizeW'($urandom_range(0, 8));
            end else if (pick < 9) begin
               sz = id3fw_pkg::SizeW'($urandom_range(9, 40));
            end else if ($urandom_range(0, 1) == 0) begin
               sz = '1;
            end else begin
               sz = id3fw_pkg::SizeW'($urandom_range(41, 32'h0FFF_FFFF));
            end
            build_header(sz, hdr);
            foreach (hdr[i]) begin
               push_byte(hdr[i], lead, 1'b1);
               lead = 1'b0;
            end
            if (sz > 40) begin
               // big payload: zero to four bytes, then the next start cuts the skip short
               n = $urandom_range(0, 4);
               cut = 1'b1;
            end else begin
               n = int'(sz);
            end
            for (int i = 0; i < n; i++) begin
               push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
         end
         if (!cut) begin
            if ($urandom_range(0, 4) == 0) begin
               // partial header, cut by the next start
               build_header(id3fw_pkg::SizeW'($urandom_range(0, 40)), hdr);
               n = $urandom_range(1, 9);
               for (int i = 0; i < n; i++) begin
                  push_byte(hdr[i], lead, 1'b1);
                  lead = 1'b0;
               end
            end else begin
               // bad byte in a random id position ends the walk
               n = $urandom_range(0, 3);
               for (int i = 0; i < n; i++) begin
                  push_byte(rand_id_byte(), lead, 1'b1);
                  lead = 1'b0;
               end
               push_byte(rand_bad_byte(), lead, 1'b1);
               if ($urandom_range(0, 3) == 0) begin
                  n = $urandom_range(1, 6);
                  for (int i = 0; i < n; i++) begin
                     push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                  end
               end
            end
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_bus.valid || frames_due.size() != 0) begin
         @(posedge clock);
      end
      // leave room for any stray item
      repeat (12) @(posedge clock);
      if (fault_count == 0 && frames_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
